@@ hw/rtl/sca_pkg.sv @@
// sca_pkg: widths, operation codes and register indexes for the scaled complex alu
// used by sca_scale, sca_qdiv and scaled_complex_alu; no dependencies
package sca_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;

    localparam int SC_OP_W   = 2;
    localparam int SC_NUM_W  = 16;
    localparam int SC_DEN_W  = 15;
    localparam int SC_OFF_W  = 16;
    localparam int SC_LIM_W  = 16;
    localparam int SC_IDX_W  = 3;
    localparam int SC_CFG_W  = 16;

    // operand scaling
    localparam int SC_MAG_W  = WORD_BITS + SC_NUM_W - 1;
    localparam int SC_OFFS_W = SC_OFF_W + FRAC_BITS;
    localparam int SC_SUM_W  = (SC_MAG_W + 2 > SC_OFFS_W + 1) ? SC_MAG_W + 2 : SC_OFFS_W + 1;

    // complex product and quotient
    localparam int SC_PROD_W   = 2 * WORD_BITS;
    localparam int SC_DN_W     = 2 * WORD_BITS + 1;
    localparam int SC_DSQ_W    = 2 * WORD_BITS;
    localparam int SC_QN_W     = SC_DN_W + FRAC_BITS;
    localparam int SC_QT_W     = SC_QN_W - WORD_BITS;
    localparam int SC_LIMCMP_W = SC_DSQ_W + SC_LIM_W + FRAC_BITS;

    // latencies in enabled cycles
    localparam int SC_LANE_LAT = SC_MAG_W + 2;
    localparam int SC_QDIV_LAT = WORD_BITS + 2;
    localparam int SC_LAT      = SC_LANE_LAT + 2 + SC_QDIV_LAT + 1;

    localparam logic [WORD_BITS-1:0] SC_WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] SC_WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam logic [SC_OP_W-1:0] SC_OP_ADD = 2'd0;
    localparam logic [SC_OP_W-1:0] SC_OP_SUB = 2'd1;
    localparam logic [SC_OP_W-1:0] SC_OP_MUL = 2'd2;
    localparam logic [SC_OP_W-1:0] SC_OP_DIV = 2'd3;

    localparam logic [SC_IDX_W-1:0] SC_REG_OP    = 3'd0;
    localparam logic [SC_IDX_W-1:0] SC_REG_A_NUM = 3'd1;
    localparam logic [SC_IDX_W-1:0] SC_REG_A_DEN = 3'd2;
    localparam logic [SC_IDX_W-1:0] SC_REG_A_OFF = 3'd3;
    localparam logic [SC_IDX_W-1:0] SC_REG_B_NUM = 3'd4;
    localparam logic [SC_IDX_W-1:0] SC_REG_B_DEN = 3'd5;
    localparam logic [SC_IDX_W-1:0] SC_REG_B_OFF = 3'd6;
    localparam logic [SC_IDX_W-1:0] SC_REG_LIM   = 3'd7;

endpackage

@@ hw/rtl/sca_scale.sv @@
// sca_scale: one operand part times num/den plus offset, saturated
// pipelined restoring divider, one quotient bit per stage; depends on sca_pkg
module sca_scale import sca_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [WORD_BITS-1:0] i_x,
    input  logic signed [SC_NUM_W-1:0]  i_num,
    input  logic [SC_DEN_W-1:0]         i_den,
    input  logic signed [SC_OFF_W-1:0]  i_offset,
    output logic signed [WORD_BITS-1:0] o_y,
    output logic                        o_sat
);

    localparam int PW = WORD_BITS + SC_NUM_W;

    logic signed [PW-1:0]       prod;
    logic [PW-1:0]              prod_abs;
    logic [SC_DEN_W-1:0]        den;
    logic                       r_neg [0:SC_MAG_W];
    logic [SC_MAG_W-1:0]        r_nq  [0:SC_MAG_W];
    logic [SC_DEN_W-1:0]        r_rem [0:SC_MAG_W];
    logic signed [SC_SUM_W-1:0] q_s;
    logic signed [SC_SUM_W-1:0] off_s;
    logic signed [SC_SUM_W-1:0] sum;
    logic                       fits;
    logic [WORD_BITS-1:0]       n_y;
    logic [WORD_BITS-1:0]       r_y;
    logic                       r_sat;

    assign prod     = i_x * i_num;
    assign prod_abs = prod[PW-1] ? $unsigned(-prod) : $unsigned(prod);
    assign den      = (i_den == '0) ? SC_DEN_W'(1) : i_den;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= prod[PW-1];
            r_nq[0]  <= prod_abs[SC_MAG_W-1:0];
            r_rem[0] <= '0;
        end
    end

    for (genvar k = 0; k < SC_MAG_W; k++) begin : g_step
        logic [SC_DEN_W:0] t;
        logic [SC_DEN_W:0] t_sub;
        logic              ge;
        assign t     = {r_rem[k], r_nq[k][SC_MAG_W-1]};
        assign t_sub = t - {1'b0, den};
        assign ge    = t >= {1'b0, den};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k+1] <= r_neg[k];
                r_rem[k+1] <= ge ? t_sub[SC_DEN_W-1:0] : t[SC_DEN_W-1:0];
                r_nq[k+1]  <= {r_nq[k][SC_MAG_W-2:0], ge};
            end
        end
    end

    always_comb begin
        q_s = $signed({{(SC_SUM_W-SC_MAG_W){1'b0}}, r_nq[SC_MAG_W]});
        if (r_neg[SC_MAG_W]) begin
            q_s = -q_s;
        end
        off_s = $signed({{(SC_SUM_W-SC_OFF_W){i_offset[SC_OFF_W-1]}}, i_offset}) <<< FRAC_BITS;
        sum   = q_s + off_s;
        fits  = (&sum[SC_SUM_W-1:WORD_BITS-1]) | ~(|sum[SC_SUM_W-1:WORD_BITS-1]);
        n_y   = fits ? sum[WORD_BITS-1:0] : (sum[SC_SUM_W-1] ? SC_WMIN : SC_WMAX);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y   <= n_y;
            r_sat <= ~fits;
        end
    end

    assign o_y   = $signed(r_y);
    assign o_sat = r_sat;

endmodule

@@ hw/rtl/sca_qdiv.sv @@
// sca_qdiv: signed (num << FRAC_BITS) / dsq truncated toward zero, saturated
// overflow test up front, then one quotient bit per stage; depends on sca_pkg
module sca_qdiv import sca_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [SC_DN_W-1:0]   i_num,
    input  logic [SC_DSQ_W-1:0]         i_dsq,
    output logic signed [WORD_BITS-1:0] o_q,
    output logic                        o_sat
);

    logic [SC_DN_W-1:0]   mag;
    logic [SC_QN_W-1:0]   nsh;
    logic [SC_QN_W-1:0]   top_x;
    logic [SC_QN_W-1:0]   dsq_x;
    logic                 ovf;
    logic                 r_neg [0:WORD_BITS];
    logic                 r_ovf [0:WORD_BITS];
    logic [SC_DSQ_W-1:0]  r_d   [0:WORD_BITS];
    logic [SC_DSQ_W-1:0]  r_rem [0:WORD_BITS];
    logic [WORD_BITS-1:0] r_lo  [0:WORD_BITS];
    logic [WORD_BITS-1:0] q;
    logic [WORD_BITS-1:0] n_q;
    logic                 n_sat;
    logic [WORD_BITS-1:0] r_q;
    logic                 r_sat;

    assign mag   = i_num[SC_DN_W-1] ? $unsigned(-i_num) : $unsigned(i_num);
    assign nsh   = {mag, {FRAC_BITS{1'b0}}};
    assign top_x = {{WORD_BITS{1'b0}}, nsh[SC_QN_W-1:WORD_BITS]};
    assign dsq_x = {{(SC_QN_W-SC_DSQ_W){1'b0}}, i_dsq};
    assign ovf   = top_x >= dsq_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg[0] <= i_num[SC_DN_W-1];
            r_ovf[0] <= ovf;
            r_d[0]   <= i_dsq;
            r_rem[0] <= ovf ? '0 : top_x[SC_DSQ_W-1:0];
            r_lo[0]  <= nsh[WORD_BITS-1:0];
        end
    end

    for (genvar k = 0; k < WORD_BITS; k++) begin : g_step
        logic [SC_DSQ_W:0] t;
        logic [SC_DSQ_W:0] t_sub;
        logic              ge;
        assign t     = {r_rem[k], r_lo[k][WORD_BITS-1]};
        assign t_sub = t - {1'b0, r_d[k]};
        assign ge    = t >= {1'b0, r_d[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
                r_d[k+1]   <= r_d[k];
                r_rem[k+1] <= ge ? t_sub[SC_DSQ_W-1:0] : t[SC_DSQ_W-1:0];
                r_lo[k+1]  <= {r_lo[k][WORD_BITS-2:0], ge};
            end
        end
    end

    assign q = r_lo[WORD_BITS];

    always_comb begin
        n_q   = q;
        n_sat = 1'b0;
        if (r_ovf[WORD_BITS]) begin
            n_sat = 1'b1;
            n_q   = r_neg[WORD_BITS] ? SC_WMIN : SC_WMAX;
        end else if (r_neg[WORD_BITS]) begin
            if (q > SC_WMIN) begin
                n_sat = 1'b1;
                n_q   = SC_WMIN;
            end else begin
                n_q = -q;
            end
        end else if (q[WORD_BITS-1]) begin
            n_sat = 1'b1;
            n_q   = SC_WMAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q   <= n_q;
            r_sat <= n_sat;
        end
    end

    assign o_q   = $signed(r_q);
    assign o_sat = r_sat;

endmodule

@@ hw/rtl/scaled_complex_alu.sv @@
// One pair of complex Q16.16 samples enters per cycle and one result leaves per cycle; the
// pipeline holds the 47 one-bit stages of the operand scale dividers and the 32 one-bit
// stages of the complex quotient divider. A stall on a valid output freezes the whole
// pipeline and holds off the input. Configuration writes are taken in any cycle.
// scaled_complex_alu: top level; depends on sca_pkg, sca_scale, sca_qdiv
module scaled_complex_alu import sca_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [WORD_BITS-1:0] i_a_real,
    input  logic signed [WORD_BITS-1:0] i_a_imag,
    input  logic signed [WORD_BITS-1:0] i_b_real,
    input  logic signed [WORD_BITS-1:0] i_b_imag,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic signed [WORD_BITS-1:0] o_res_real,
    output logic signed [WORD_BITS-1:0] o_res_imag,
    output logic                        o_saturated,
    output logic                        o_divisor_small,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [SC_IDX_W-1:0]         i_cfg_index,
    input  logic [SC_CFG_W-1:0]         i_cfg_data
);

    typedef struct packed {
        logic [WORD_BITS-1:0] re;
        logic [WORD_BITS-1:0] im;
        logic                 sat;
        logic                 div_small;
        logic                 div;
    } t_res;

    logic                       en;
    logic                       r_vld [0:SC_LAT-1];

    logic [SC_OP_W-1:0]         r_op;
    logic signed [SC_NUM_W-1:0] r_a_num;
    logic [SC_DEN_W-1:0]        r_a_den;
    logic signed [SC_OFF_W-1:0] r_a_off;
    logic signed [SC_NUM_W-1:0] r_b_num;
    logic [SC_DEN_W-1:0]        r_b_den;
    logic signed [SC_OFF_W-1:0] r_b_off;
    logic [SC_LIM_W-1:0]        r_lim;

    logic signed [WORD_BITS-1:0] ar, ai, br, bi;
    logic                        sat_ar, sat_ai, sat_br, sat_bi;

    logic signed [SC_PROD_W-1:0] p_rr, p_ii, p_ri, p_ir, p_bbr, p_bbi;
    logic signed [WORD_BITS:0]   as_re, as_im;
    logic                        as_re_fit, as_im_fit;
    logic signed [SC_PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bbr, r_p_bbi;
    logic [WORD_BITS-1:0]        r_p_as_re, r_p_as_im;
    logic                        r_p_as_sat, r_p_lsat;

    logic signed [SC_DN_W-1:0]           m_re, m_im, dn_re, dn_im;
    logic [SC_DN_W-FRAC_BITS-1:0]        ms_re, ms_im;
    logic                                ms_re_fit, ms_im_fit;
    logic [SC_DSQ_W-1:0]                 dsq;
    t_res                                n_s;
    t_res                                r_s;
    logic signed [SC_DN_W-1:0]           r_s_dn_re, r_s_dn_im;
    logic [SC_DSQ_W-1:0]                 r_s_dsq;
    logic                                dsq_low;

    t_res                        r_dly [0:SC_QDIV_LAT-1];
    t_res                        dly_in;
    logic signed [WORD_BITS-1:0] q_re, q_im;
    logic                        q_re_sat, q_im_sat;
    t_res                        n_o;
    t_res                        r_o;

    assign o_valid     = r_vld[SC_LAT-1];
    assign en          = ~r_vld[SC_LAT-1] | ~i_stall;
    assign o_stall     = ~en;
    assign o_cfg_ready = 1'b1;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= SC_OP_ADD;
            r_a_num <= SC_NUM_W'(1);
            r_a_den <= SC_DEN_W'(1);
            r_a_off <= '0;
            r_b_num <= SC_NUM_W'(1);
            r_b_den <= SC_DEN_W'(1);
            r_b_off <= '0;
            r_lim   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                SC_REG_OP:    r_op    <= i_cfg_data[SC_OP_W-1:0];
                SC_REG_A_NUM: r_a_num <= $signed(i_cfg_data[SC_NUM_W-1:0]);
                SC_REG_A_DEN: r_a_den <= i_cfg_data[SC_DEN_W-1:0];
                SC_REG_A_OFF: r_a_off <= $signed(i_cfg_data[SC_OFF_W-1:0]);
                SC_REG_B_NUM: r_b_num <= $signed(i_cfg_data[SC_NUM_W-1:0]);
                SC_REG_B_DEN: r_b_den <= i_cfg_data[SC_DEN_W-1:0];
                SC_REG_B_OFF: r_b_off <= $signed(i_cfg_data[SC_OFF_W-1:0]);
                SC_REG_LIM:   r_lim   <= i_cfg_data[SC_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SC_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < SC_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // operand scaling
    sca_scale u_scale_ar (
        .i_clk(i_clk), .i_en(en), .i_x(i_a_real), .i_num(r_a_num), .i_den(r_a_den),
        .i_offset(r_a_off), .o_y(ar), .o_sat(sat_ar)
    );
    sca_scale u_scale_ai (
        .i_clk(i_clk), .i_en(en), .i_x(i_a_imag), .i_num(r_a_num), .i_den(r_a_den),
        .i_offset(SC_OFF_W'(0)), .o_y(ai), .o_sat(sat_ai)
    );
    sca_scale u_scale_br (
        .i_clk(i_clk), .i_en(en), .i_x(i_b_real), .i_num(r_b_num), .i_den(r_b_den),
        .i_offset(r_b_off), .o_y(br), .o_sat(sat_br)
    );
    sca_scale u_scale_bi (
        .i_clk(i_clk), .i_en(en), .i_x(i_b_imag), .i_num(r_b_num), .i_den(r_b_den),
        .i_offset(SC_OFF_W'(0)), .o_y(bi), .o_sat(sat_bi)
    );

    // products and add or subtract
    assign p_rr  = ar * br;
    assign p_ii  = ai * bi;
    assign p_ri  = ar * bi;
    assign p_ir  = ai * br;
    assign p_bbr = br * br;
    assign p_bbi = bi * bi;

    always_comb begin
        if (r_op == SC_OP_SUB) begin
            as_re = {ar[WORD_BITS-1], ar} - {br[WORD_BITS-1], br};
            as_im = {ai[WORD_BITS-1], ai} - {bi[WORD_BITS-1], bi};
        end else begin
            as_re = {ar[WORD_BITS-1], ar} + {br[WORD_BITS-1], br};
            as_im = {ai[WORD_BITS-1], ai} + {bi[WORD_BITS-1], bi};
        end
        as_re_fit = as_re[WORD_BITS] == as_re[WORD_BITS-1];
        as_im_fit = as_im[WORD_BITS] == as_im[WORD_BITS-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_rr     <= p_rr;
            r_p_ii     <= p_ii;
            r_p_ri     <= p_ri;
            r_p_ir     <= p_ir;
            r_p_bbr    <= p_bbr;
            r_p_bbi    <= p_bbi;
            r_p_as_re  <= as_re_fit ? as_re[WORD_BITS-1:0]
                                    : (as_re[WORD_BITS] ? SC_WMIN : SC_WMAX);
            r_p_as_im  <= as_im_fit ? as_im[WORD_BITS-1:0]
                                    : (as_im[WORD_BITS] ? SC_WMIN : SC_WMAX);
            r_p_as_sat <= ~as_re_fit | ~as_im_fit;
            r_p_lsat   <= sat_ar | sat_ai | sat_br | sat_bi;
        end
    end

    // sums of products, multiply result, divider operands
    always_comb begin
        m_re  = {r_p_rr[SC_PROD_W-1], r_p_rr} - {r_p_ii[SC_PROD_W-1], r_p_ii};
        m_im  = {r_p_ri[SC_PROD_W-1], r_p_ri} + {r_p_ir[SC_PROD_W-1], r_p_ir};
        dn_re = {r_p_rr[SC_PROD_W-1], r_p_rr} + {r_p_ii[SC_PROD_W-1], r_p_ii};
        dn_im = {r_p_ir[SC_PROD_W-1], r_p_ir} - {r_p_ri[SC_PROD_W-1], r_p_ri};
        dsq   = $unsigned(r_p_bbr) + $unsigned(r_p_bbi);
        ms_re = m_re[SC_DN_W-1:FRAC_BITS];
        ms_im = m_im[SC_DN_W-1:FRAC_BITS];
        ms_re_fit = (&ms_re[SC_DN_W-FRAC_BITS-1:WORD_BITS-1])
                  | ~(|ms_re[SC_DN_W-FRAC_BITS-1:WORD_BITS-1]);
        ms_im_fit = (&ms_im[SC_DN_W-FRAC_BITS-1:WORD_BITS-1])
                  | ~(|ms_im[SC_DN_W-FRAC_BITS-1:WORD_BITS-1]);
        n_s       = '0;
        n_s.sat   = r_p_lsat;
        case (r_op)
            SC_OP_ADD, SC_OP_SUB: begin
                n_s.re  = r_p_as_re;
                n_s.im  = r_p_as_im;
                n_s.sat = r_p_lsat | r_p_as_sat;
            end
            SC_OP_MUL: begin
                n_s.re  = ms_re_fit ? ms_re[WORD_BITS-1:0]
                                    : (ms_re[SC_DN_W-FRAC_BITS-1] ? SC_WMIN : SC_WMAX);
                n_s.im  = ms_im_fit ? ms_im[WORD_BITS-1:0]
                                    : (ms_im[SC_DN_W-FRAC_BITS-1] ? SC_WMIN : SC_WMAX);
                n_s.sat = r_p_lsat | ~ms_re_fit | ~ms_im_fit;
            end
            SC_OP_DIV: begin
                n_s.div = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s       <= n_s;
            r_s_dn_re <= dn_re;
            r_s_dn_im <= dn_im;
            r_s_dsq   <= dsq;
        end
    end

    // complex quotient
    sca_qdiv u_qdiv_re (
        .i_clk(i_clk), .i_en(en), .i_num(r_s_dn_re), .i_dsq(r_s_dsq),
        .o_q(q_re), .o_sat(q_re_sat)
    );
    sca_qdiv u_qdiv_im (
        .i_clk(i_clk), .i_en(en), .i_num(r_s_dn_im), .i_dsq(r_s_dsq),
        .o_q(q_im), .o_sat(q_im_sat)
    );

    assign dsq_low = (r_s_dsq == '0)
                   | ({{(SC_LIMCMP_W-SC_DSQ_W){1'b0}}, r_s_dsq}
                      < {{SC_DSQ_W{1'b0}}, r_lim, {FRAC_BITS{1'b0}}});

    always_comb begin
        dly_in           = r_s;
        dly_in.div_small = r_s.div & dsq_low;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= dly_in;
            for (int k = 1; k < SC_QDIV_LAT; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    // result select
    always_comb begin
        n_o = r_dly[SC_QDIV_LAT-1];
        if (n_o.div) begin
            if (n_o.div_small) begin
                n_o.re = '0;
                n_o.im = '0;
            end else begin
                n_o.re  = q_re;
                n_o.im  = q_im;
                n_o.sat = n_o.sat | q_re_sat | q_im_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o <= n_o;
        end
    end

    assign o_res_real      = $signed(r_o.re);
    assign o_res_imag      = $signed(r_o.im);
    assign o_saturated     = r_o.sat;
    assign o_divisor_small = r_o.div_small;

endmodule
